@@ design/bra_pkg.sv @@
// shared constants, codes and types of the byte ring fifo
package bra_pkg;

   localparam int MAX_BYTES = 4;
   localparam int NLANES    = MAX_BYTES;
   localparam int LANE_BITS = $clog2(NLANES);
   localparam int BYTE_W    = 8;
   localparam int DATA_W    = 32;
   localparam int LEN_W     = 3;
   localparam int FILL_W    = 8;
   localparam int CAP_W     = 4;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   localparam logic [CAP_W-1:0] CAP_RESET     = 4'd8;
   localparam logic [0:0]       CSR_CAP_INDEX = 1'b0;

   typedef enum logic [2:0] {
      KIND_WRITE = 3'd0,
      KIND_POP   = 3'd1,
      KIND_PEEK  = 3'd2,
      KIND_SKIP  = 3'd3,
      KIND_CLEAR = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_DONE   = 2'd0,
      STATUS_SHORT  = 2'd1,
      STATUS_REJECT = 2'd2
   } status_type;

   // access command handed to every lane
   typedef struct packed {
      logic             wr;
      logic             rd;
      logic [LEN_W-1:0] count;
   } bra_cmd_type;

   // what one lane read, and where its byte goes in the word
   typedef struct packed {
      logic                 hit;
      logic [LANE_BITS-1:0] slot;
      logic [BYTE_W-1:0]    data;
   } bra_lane_rd_type;

endpackage

@@ design/bra_req_if.sv @@
// request channel: one fifo operation per transaction
interface bra_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [31:0] write_data;
   logic [2:0]  length;
   logic [7:0]  offset;

   modport source (output valid, kind, write_data, length, offset, input ready);
   modport sink (input valid, kind, write_data, length, offset, output ready);
endinterface

@@ design/bra_rsp_if.sv @@
// response channel: one result per fifo operation
interface bra_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic [2:0]  byte_count;
   logic [7:0]  fill_level;
   logic [1:0]  status;

   modport source (output valid, read_data, byte_count, fill_level, status, input ready);
   modport sink (input valid, read_data, byte_count, fill_level, status, output ready);
endinterface

@@ design/bra_lane.sv @@
// one byte lane: a bank of the ring holding every address whose low bits match the lane
module bra_lane
   import bra_pkg::*;
#(
   parameter int DEPTH_LOG2 = 8,
   parameter int LANE       = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bra_cmd_type           cmd,
   input  logic [DEPTH_LOG2-1:0] start,
   input  logic [DEPTH_LOG2-1:0] mask,
   input  logic [DATA_W-1:0]     write_data,
   output bra_lane_rd_type       rd_out
);

   localparam int BANK_AW    = (DEPTH_LOG2 > LANE_BITS) ? DEPTH_LOG2 - LANE_BITS : 1;
   localparam int BANK_DEPTH = 1 << BANK_AW;

   logic [BYTE_W-1:0]     bank_mem [BANK_DEPTH];
   logic [LANE_BITS-1:0]  slot;
   logic                  active;
   logic [DEPTH_LOG2-1:0] addr;
   logic [BANK_AW-1:0]    bank_addr;
   logic [BYTE_W-1:0]     wbyte;
   logic                  hit_ff;
   logic [LANE_BITS-1:0]  slot_ff;
   logic [BYTE_W-1:0]     data_ff;

   // position of this lane's byte within the transaction
   assign slot      = LANE_BITS'(LANE) - start[LANE_BITS-1:0];
   assign active    = LEN_W'(slot) < cmd.count;
   assign addr      = (start + DEPTH_LOG2'(slot)) & mask;
   assign bank_addr = BANK_AW'(addr >> LANE_BITS);
   assign wbyte     = write_data[{slot, 3'b000} +: BYTE_W];

   always_ff @(posedge clock) begin
      if (cmd.wr && active) begin
         bank_mem[bank_addr] <= wbyte;
      end
      if (cmd.rd) begin
         data_ff <= bank_mem[bank_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= 1'b0;
         slot_ff <= '0;
      end else if (cmd.wr || cmd.rd) begin
         hit_ff  <= cmd.rd && active;
         slot_ff <= slot;
      end
   end

   assign rd_out.hit  = hit_ff;
   assign rd_out.slot = slot_ff;
   assign rd_out.data = data_ff;

endmodule

@@ design/bra_merge.sv @@
// packs the lane bytes into one little-endian word, zero where no lane read
module bra_merge
   import bra_pkg::*;
(
   input  bra_lane_rd_type   lanes [NLANES],
   output logic [DATA_W-1:0] read_data
);

   always_comb begin
      read_data = '0;
      for (int l = 0; l < NLANES; l++) begin
         if (lanes[l].hit) begin
            read_data[{lanes[l].slot, 3'b000} +: BYTE_W] =
               read_data[{lanes[l].slot, 3'b000} +: BYTE_W] | lanes[l].data;
         end
      end
   end

endmodule

@@ design/byte_ring_fifo_with_peek.sv @@
// byte ring fifo with peek: top level with control, pointers and register port
//
// req_if carries one operation per transaction: write up to 4 bytes, pop, peek
// at an offset from the head, skip a count of bytes, or clear. rsp_if returns
// exactly one result per operation: bytes read, byte count, fill level after
// the operation and a status (done, short or clamped, write rejected).
// The ring is split into four byte lanes that work side by side, so all bytes
// of one operation move in the same memory access; a merge stage packs them.
// An operation runs through four steps: accept, plan (fill level, counts, pointer
// update), lane memory access, merge into the output register. One operation
// is in flight at a time, so a new operation is not taken until the last one
// has left merge; the pace is set by the four-step control sequence.
// req_if.ready is high while the control is idle, also while a result waits.
// If the receiver stalls, the result holds in the output register and the
// next operation stops at merge until that register frees up.
// Reset empties the fifo (head and tail at zero) and sets capacity_log2 to 8;
// the byte store is not cleared and no clearing pass runs.
// capacity_log2 sits at csr address 0; the user must write it only while idle, the block does not enforce this.
module byte_ring_fifo_with_peek
   import bra_pkg::*;
#(
   parameter int DEPTH_LOG2 = 8
) (
   input  logic              clock,
   input  logic              reset,
   bra_req_if.sink           req_if,
   bra_rsp_if.source         rsp_if,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int CMP_W  = (DEPTH_LOG2 > FILL_W) ? DEPTH_LOG2 : FILL_W;
   localparam int CAPE_W = $clog2(DEPTH_LOG2 + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PLAN,
      ST_ACCESS,
      ST_MERGE
   } state_type;

   state_type             state_ff;
   logic [CAP_W-1:0]      cap_ff;
   logic [DEPTH_LOG2-1:0] head_ff, tail_ff, start_ff;
   logic [DEPTH_LOG2-1:0] head_in, tail_in, start_in;
   kind_type              kind_ff;
   logic [DATA_W-1:0]     wdata_ff;
   logic [LEN_W-1:0]      length_ff;
   logic [7:0]            offset_ff;
   bra_cmd_type           cmd_ff, cmd_in, lane_cmd;
   status_type            status_ff, status_in;
   logic [FILL_W-1:0]     fill_ff;
   logic                  rsp_valid_ff;
   logic [DATA_W-1:0]     rsp_data_ff;
   logic [LEN_W-1:0]      rsp_count_ff;
   logic [FILL_W-1:0]     rsp_fill_ff;
   status_type            rsp_status_ff;

   logic [CAPE_W-1:0]     cap_eff;
   logic [DEPTH_LOG2:0]   one_sh;
   logic [DEPTH_LOG2-1:0] mask;
   logic [DEPTH_LOG2-1:0] fill;
   logic [CMP_W-1:0]      fill_x, len_x, ofs_x, room_x, avail_x, nskip_x;
   logic [LEN_W-1:0]      len_sat, n_rd;
   logic                  csr_wr, out_free;
   bra_lane_rd_type       lane_rd [NLANES];
   logic [DATA_W-1:0]     merged;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[CSR_AW-1:2] == CSR_CAP_INDEX);
   assign csr_prdata = (csr_paddr[CSR_AW-1:2] == CSR_CAP_INDEX) ? CSR_DW'(cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_wr) begin
         cap_ff <= csr_pwdata[CAP_W-1:0];
      end
   end

   // ring mask from the clamped capacity
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CAPE_W'(1);
      end else if (int'(cap_ff) > DEPTH_LOG2) begin
         cap_eff = CAPE_W'(DEPTH_LOG2);
      end else begin
         cap_eff = CAPE_W'(cap_ff);
      end
   end

   assign one_sh = (DEPTH_LOG2 + 1)'(1) << cap_eff;
   assign mask   = DEPTH_LOG2'(one_sh - 1'b1);
   assign fill   = (tail_ff - head_ff) & mask;

   assign fill_x  = CMP_W'(fill);
   assign len_sat = (length_ff > LEN_W'(MAX_BYTES)) ? LEN_W'(MAX_BYTES) : length_ff;
   assign len_x   = CMP_W'(len_sat);
   assign ofs_x   = CMP_W'(offset_ff);
   assign room_x  = CMP_W'(mask - fill);
   assign avail_x = fill_x - ofs_x;
   assign nskip_x = (ofs_x < fill_x) ? ofs_x : fill_x;

   // operation plan: counts, status and new pointers
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      start_in  = head_ff & mask;
      cmd_in    = '0;
      status_in = STATUS_DONE;
      n_rd      = '0;
      unique case (kind_ff)
         KIND_WRITE: begin
            if (room_x < len_x) begin
               status_in = STATUS_REJECT;
            end else begin
               cmd_in.wr    = 1'b1;
               cmd_in.count = len_sat;
               start_in     = tail_ff & mask;
               tail_in      = (tail_ff + DEPTH_LOG2'(len_sat)) & mask;
            end
         end
         KIND_POP: begin
            n_rd         = (fill_x < len_x) ? LEN_W'(fill_x) : len_sat;
            cmd_in.rd    = 1'b1;
            cmd_in.count = n_rd;
            head_in      = (head_ff + DEPTH_LOG2'(n_rd)) & mask;
            status_in    = (n_rd < len_sat) ? STATUS_SHORT : STATUS_DONE;
         end
         KIND_PEEK: begin
            if (ofs_x < fill_x) begin
               n_rd = (avail_x < len_x) ? LEN_W'(avail_x) : len_sat;
            end
            cmd_in.rd    = 1'b1;
            cmd_in.count = n_rd;
            start_in     = (head_ff + DEPTH_LOG2'(offset_ff)) & mask;
            status_in    = (n_rd < len_sat) ? STATUS_SHORT : STATUS_DONE;
         end
         KIND_SKIP: begin
            head_in   = (head_ff + DEPTH_LOG2'(nskip_x)) & mask;
            status_in = (fill_x < ofs_x) ? STATUS_SHORT : STATUS_DONE;
         end
         KIND_CLEAR: begin
            head_in = tail_ff & mask;
            tail_in = tail_ff & mask;
         end
         default: begin
            head_in = head_ff;
         end
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         cmd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_if.ready && (state_ff != ST_MERGE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_if.valid) begin
                  kind_ff   <= kind_type'(req_if.kind);
                  wdata_ff  <= req_if.write_data;
                  length_ff <= req_if.length;
                  offset_ff <= req_if.offset;
                  state_ff  <= ST_PLAN;
               end
            end
            ST_PLAN: begin
               head_ff   <= head_in;
               tail_ff   <= tail_in;
               start_ff  <= start_in;
               cmd_ff    <= cmd_in;
               status_ff <= status_in;
               state_ff  <= ST_ACCESS;
            end
            ST_ACCESS: begin
               // pointers already hold the post-operation values
               fill_ff  <= fill_x[FILL_W-1:0];
               state_ff <= ST_MERGE;
            end
            ST_MERGE: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  // lanes keep their last read flags when nothing was read
                  rsp_data_ff   <= cmd_ff.rd ? merged : '0;
                  rsp_count_ff  <= cmd_ff.count;
                  rsp_fill_ff   <= fill_ff;
                  rsp_status_ff <= status_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_if.ready = (state_ff == ST_IDLE);

   assign lane_cmd.wr    = cmd_ff.wr && (state_ff == ST_ACCESS);
   assign lane_cmd.rd    = cmd_ff.rd && (state_ff == ST_ACCESS);
   assign lane_cmd.count = cmd_ff.count;

   for (genvar l = 0; l < NLANES; l++) begin : g_lane
      bra_lane #(
         .DEPTH_LOG2 (DEPTH_LOG2),
         .LANE       (l)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .cmd        (lane_cmd),
         .start      (start_ff),
         .mask       (mask),
         .write_data (wdata_ff),
         .rd_out     (lane_rd[l])
      );
   end

   bra_merge u_merge (
      .lanes     (lane_rd),
      .read_data (merged)
   );

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.read_data  = rsp_data_ff;
   assign rsp_if.byte_count = rsp_count_ff;
   assign rsp_if.fill_level = rsp_fill_ff;
   assign rsp_if.status     = rsp_status_ff;

endmodule

@@ design/bra_checker.sv @@
// port-level checks of the byte ring fifo, bound to the top level
module bra_checker
   import bra_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DATA_W-1:0] rsp_read_data,
   input logic [LEN_W-1:0]  rsp_byte_count,
   input logic [1:0]        rsp_status
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_read_data) && $stable(rsp_byte_count))
      else $error("stalled response changed");

   // one operation in flight: no second transaction right after an accepted one
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while an operation is in flight");

   // count in range and bytes above the count are zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_byte_count <= LEN_W'(MAX_BYTES)) &&
         (rsp_byte_count >= 3'd4 || rsp_read_data[31:24] == 8'h00) &&
         (rsp_byte_count >= 3'd3 || rsp_read_data[31:16] == 16'h0000) &&
         (rsp_byte_count >= 3'd2 || rsp_read_data[31:8] == 24'h000000) &&
         (rsp_byte_count >= 3'd1 || rsp_read_data == 32'h0))
      else $error("read data not zero above byte count");

   // a rejected write moves nothing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_REJECT) |->
         (rsp_byte_count == 3'd0) && (rsp_read_data == 32'h0))
      else $error("rejected write reports data");

endmodule

bind byte_ring_fifo_with_peek bra_checker u_bra_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_read_data  (rsp_if.read_data),
   .rsp_byte_count (rsp_if.byte_count),
   .rsp_status     (rsp_if.status)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// testbench for the byte ring fifo: directed and random operations checked against a ring model
module tb_top;
   import bra_pkg::*;

   localparam int RING_LOG2   = 8;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE      = 10;
   localparam int DRAIN_LIMIT = 2000;
   localparam logic [CSR_AW-1:0] CAP_ADDR = CSR_AW'(4 * int'(CSR_CAP_INDEX));

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic [LEN_W-1:0]  count;
      logic [FILL_W-1:0] level;
      logic [1:0]        status;
   } ring_result_type;

   // ring model, expected results in order, and the result check
   class ring_checker;
      logic [BYTE_W-1:0] ring_bytes [1 << RING_LOG2];
      logic [7:0]        head;
      logic [7:0]        tail;
      logic [CAP_W-1:0]  cap;
      ring_result_type   due_results[$];
      int                mismatches;

      function new();
         head       = '0;
         tail       = '0;
         cap        = CAP_RESET;
         mismatches = 0;
      endfunction

      function int mask();
         int c;
         c = cap;
         if (c < 1) c = 1;
         if (c > RING_LOG2) c = RING_LOG2;
         return (1 << c) - 1;
      endfunction

      function int held();
         return (int'(tail) - int'(head)) & mask();
      endfunction

      function int room();
         return mask() - held();
      endfunction

      function logic [DATA_W-1:0] gather(int start, int n);
         logic [DATA_W-1:0] v;
         v = '0;
         for (int i = 0; i < n; i++) v[8*i +: 8] = ring_bytes[(start + i) & mask()];
         return v;
      endfunction

      function void apply_op(logic [2:0] kind, logic [DATA_W-1:0] wdata,
                             logic [LEN_W-1:0] length, logic [7:0] ofs);
         int              m;
         int              fill;
         int              len;
         int              n;
         ring_result_type r;
         m    = mask();
         fill = held();
         len  = (length > MAX_BYTES) ? MAX_BYTES : int'(length);
         r    = '0;
         n    = 0;
         case (kind)
            KIND_WRITE: begin
               if (m - fill < len) begin
                  r.status = STATUS_REJECT;
               end else begin
                  for (int i = 0; i < len; i++)
                     ring_bytes[(int'(tail) + i) & m] = wdata[8*i +: 8];
                  tail    = 8'((int'(tail) + len) & m);
                  r.count = LEN_W'(len);
               end
            end
            KIND_POP: begin
               n       = (len < fill) ? len : fill;
               r.data  = gather(int'(head), n);
               head    = 8'((int'(head) + n) & m);
               r.count = LEN_W'(n);
               if (n < len) r.status = STATUS_SHORT;
            end
            KIND_PEEK: begin
               if (int'(ofs) < fill) begin
                  n = fill - int'(ofs);
                  if (n > len) n = len;
                  r.data = gather(int'(head) + int'(ofs), n);
               end
               r.count = LEN_W'(n);
               if (n < len) r.status = STATUS_SHORT;
            end
            KIND_SKIP: begin
               n    = (int'(ofs) < fill) ? int'(ofs) : fill;
               head = 8'((int'(head) + n) & m);
               if (n < int'(ofs)) r.status = STATUS_SHORT;
            end
            KIND_CLEAR: begin
               head = 8'(int'(tail) & m);
               tail = 8'(int'(tail) & m);
            end
            default: ;
         endcase
         r.level = FILL_W'(held());
         due_results.push_back(r);
      endfunction

      function void compare(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void match_result(ring_result_type got);
         ring_result_type want;
         if (due_results.size() == 0) begin
            $display("%0t: result with nothing pending: data %0h count %0d fill %0d status %0d",
                     $time, got.data, got.count, got.level, got.status);
            mismatches++;
         end else begin
            want = due_results.pop_front();
            compare("read_data", want.data, got.data);
            compare("byte_count", DATA_W'(want.count), DATA_W'(got.count));
            compare("fill_level", DATA_W'(want.level), DATA_W'(got.level));
            compare("status", DATA_W'(want.status), DATA_W'(got.status));
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;
   int                cycles = 0;
   bit                steady = 1'b0;
   ring_checker       sb;

   bra_req_if req_bus();
   bra_rsp_if rsp_bus();

   byte_ring_fifo_with_peek #(
      .DEPTH_LOG2(RING_LOG2)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_bus),
      .rsp_if     (rsp_bus),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results pending", $time, sb.due_results.size());
         $display("** byte_ring_fifo_with_peek: FAILED **");
         $finish;
      end
   end

   task automatic send_op(input logic [2:0] kind, input logic [DATA_W-1:0] wdata,
                          input logic [LEN_W-1:0] length, input logic [7:0] ofs);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.kind       <= kind;
      req_bus.write_data <= wdata;
      req_bus.length     <= length;
      req_bus.offset     <= ofs;
      do @(posedge clock); while (!req_bus.ready);
      sb.apply_op(kind, wdata, length, ofs);
   endtask

   task automatic csr_write(input logic [CSR_DW-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CAP_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_check(input logic [CSR_DW-1:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CAP_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) begin
         $display("%0t: capacity_log2 readback expected %0h actual %0h",
                  $time, want, csr_prdata);
         sb.mismatches++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // empty the ring before the mask changes so no unwritten slot becomes readable
   task automatic change_capacity(input logic [CAP_W-1:0] cap);
      send_op(KIND_CLEAR, $urandom, 3'($urandom_range(0, 7)), 8'($urandom));
      req_bus.valid <= 1'b0;
      while (sb.due_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_write(CSR_DW'(cap));
      sb.cap = cap;
      // let the clock run idle between the write and the readback
      @(posedge clock);
      csr_check(CSR_DW'(cap));
   endtask

   task automatic fill_up();
      while (sb.room() >= MAX_BYTES) send_op(KIND_WRITE, $urandom, 3'(MAX_BYTES), 8'($urandom));
      while (sb.room() > 0) send_op(KIND_WRITE, $urandom, 3'd1, 8'($urandom));
      // full: this one must be turned away
      send_op(KIND_WRITE, $urandom, 3'($urandom_range(1, MAX_BYTES)), 8'($urandom));
   endtask

   task automatic run_random(input int count);
      int              roll;
      int              lvl;
      bit              filling;
      logic [2:0]      kind;
      logic [LEN_W-1:0] len;
      logic [7:0]      ofs;
      filling = 1'b0;
      for (int k = 0; k < count; k++) begin
         if (k % 30 == 0) begin
            filling = $urandom_range(0, 1);
            steady  = ($urandom_range(0, 4) == 0);
         end
         roll = $urandom_range(0, 99);
         lvl  = sb.held();
         len  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                            : 3'($urandom_range(1, MAX_BYTES));
         ofs  = 8'($urandom);
         if (filling)
            kind = (roll < 65) ? KIND_WRITE : (roll < 78) ? KIND_POP : (roll < 90) ? KIND_PEEK :
                   (roll < 96) ? KIND_SKIP : (roll < 98) ? KIND_CLEAR :
                   3'(KIND_CLEAR) + 3'($urandom_range(1, 3));
         else
            kind = (roll < 25) ? KIND_WRITE : (roll < 55) ? KIND_POP : (roll < 78) ? KIND_PEEK :
                   (roll < 93) ? KIND_SKIP : (roll < 97) ? KIND_CLEAR :
                   3'(KIND_CLEAR) + 3'($urandom_range(1, 3));
         if (kind == KIND_PEEK && $urandom_range(0, 3) != 0) ofs = 8'($urandom_range(0, lvl));
         if (kind == KIND_SKIP && $urandom_range(0, 3) != 0) ofs = 8'($urandom_range(0, 6));
         send_op(kind, $urandom, len, ofs);
      end
      steady = 1'b0;
   endtask

   initial begin : rsp_sink
      int              stall;
      ring_result_type got;
      do @(posedge clock); while (reset);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.data   = rsp_bus.read_data;
         got.count  = rsp_bus.byte_count;
         got.level  = rsp_bus.fill_level;
         got.status = rsp_bus.status;
         sb.match_result(got);
      end
   end

   initial begin : stimulus
      logic [CAP_W-1:0] caps [11] = '{4'd1, 4'd2, 4'd0, 4'd3, 4'd15, 4'd4, 4'd9, 4'd5,
                                      4'd6, 4'd7, 4'd8};
      int               drain;
      sb                 = new();
      req_bus.valid      = 1'b0;
      req_bus.kind       = KIND_WRITE;
      req_bus.write_data = '0;
      req_bus.length     = '0;
      req_bus.offset     = '0;
      rsp_bus.ready      = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check(CSR_DW'(CAP_RESET));

      // empty ring reads and skips, then writes of every length from 0 to 4 and an over-long one
      send_op(KIND_POP, 32'h0, 3'd4, 8'd0);
      send_op(KIND_PEEK, 32'h0, 3'd4, 8'd0);
      send_op(KIND_SKIP, 32'h0, 3'd1, 8'd5);
      send_op(KIND_WRITE, 32'hDEADBEEF, 3'd4, 8'd0);
      send_op(KIND_WRITE, 32'hFFFFFFFF, 3'd1, 8'hFF);
      send_op(KIND_WRITE, 32'hA5A5A5A5, 3'd0, 8'd0);
      send_op(KIND_WRITE, 32'h12345678, 3'd7, 8'd0);
      send_op(KIND_WRITE, 32'h00C0FFEE, 3'd3, 8'd0);
      send_op(KIND_WRITE, 32'h0000BEAD, 3'd2, 8'd0);
      // peeks: in range, running off the end, past the end, zero length, over-long length
      send_op(KIND_PEEK, 32'h0, 3'd4, 8'd0);
      send_op(KIND_PEEK, 32'h0, 3'd4, 8'd12);
      send_op(KIND_PEEK, 32'h0, 3'd2, 8'd255);
      send_op(KIND_PEEK, 32'h0, 3'd0, 8'd0);
      send_op(KIND_PEEK, 32'h0, 3'd6, 8'd1);
      send_op(KIND_POP, 32'h0, 3'd2, 8'd0);
      send_op(KIND_POP, 32'h0, 3'd5, 8'd0);
      send_op(KIND_POP, 32'h0, 3'd0, 8'd0);
      send_op(KIND_SKIP, 32'h0, 3'd0, 8'd0);
      send_op(KIND_SKIP, 32'h0, 3'd0, 8'd2);
      // codes above clear do nothing
      for (int k = 1; k <= 3; k++) send_op(3'(KIND_CLEAR) + 3'(k), 32'hFFFFFFFF, 3'd7, 8'hFF);
      send_op(KIND_CLEAR, 32'h0, 3'd0, 8'd0);
      send_op(KIND_POP, 32'h0, 3'd3, 8'd0);
      send_op(KIND_SKIP, 32'h0, 3'd0, 8'd255);

      for (int p = 0; p < 11; p++) begin
         change_capacity(caps[p]);
         fill_up();
         run_random((p == 10) ? 120 : 32);
      end

      req_bus.valid <= 1'b0;
      drain = 0;
      while (sb.due_results.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE) @(posedge clock);
      if (sb.due_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, sb.due_results.size());
         sb.mismatches++;
      end
      if (sb.mismatches == 0)
         $display("** byte_ring_fifo_with_peek: PASSED **");
      else
         $display("** byte_ring_fifo_with_peek: FAILED **");
      $finish;
   end

endmodule
